[hdl/two_class_priority_ticket_queue_defines.svh]
// ----------------------------------------------------------------------------
// Ticket queue assertion macros
// Shared concurrent assertion forms for the ticket queue checker.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_TICKET_QUEUE_DEFINES_SVH
`define TWO_CLASS_PRIORITY_TICKET_QUEUE_DEFINES_SVH

// same-cycle implication
`define TCPQ_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCPQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tcpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ticket queue package
// Types, codes and helpers shared by the ticket queue cells, top and checker.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned NUMBER_BITS_DEF = 16;

  localparam logic [2:0] TYPE_UNKNOWN = 3'd6;

  typedef enum logic [1:0] {
    OPC_ISSUE  = 2'd0,
    OPC_SERVE  = 2'd1,
    OPC_CANCEL = 2'd2,
    OPC_NOP    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SERVE  = 2'd2,
    CELL_CANCEL = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e   op;
    logic [2:0] stype;
    logic       prio;
  } cell_cmd_t;

  typedef struct packed {
    opcode_e     opcode;
    logic [2:0]  service_type;
    logic        priority_req;
    logic [15:0] ticket_number;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] out_number;
    logic [2:0]  out_type;
    logic        out_priority;
    logic [4:0]  occupancy;
  } out_item_t;

  // fold the unused type code onto unknown
  function automatic logic [2:0] norm_type(input logic [2:0] t);
    norm_type = (t > TYPE_UNKNOWN) ? TYPE_UNKNOWN : t;
  endfunction

endpackage
`default_nettype wire

[hdl/two_class_priority_ticket_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-class priority ticket queue
// Bounded ticket queue, priority class ahead of normal class, with issue,
// serve and cancel, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Every operation is done at the accepting edge and its result lands in the
// output register at that same edge, so with the output side free the block
// takes one operation per cycle; an operation waits only while a finished
// result is still stalled. All slots update in parallel; the longest path is
// the cancel match that ripples through the row of QUEUE_DEPTH cells to find
// the first matching ticket. No clearing pass is needed after reset, since
// slots past the fill count are never read.
module two_class_priority_ticket_queue #(
  parameter int unsigned QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned NUMBER_BITS = tcpq_pkg::NUMBER_BITS_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  tcpq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output tcpq_pkg::out_item_t out_item_o
);
  import tcpq_pkg::*;

  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CountW-1:0] FullCount = CountW'(QUEUE_DEPTH);

  logic [CountW-1:0]      count_q, count_d;
  logic [CountW-1:0]      pcount_q, pcount_d;
  logic [NUMBER_BITS-1:0] counter_q, counter_d;
  logic                   out_valid_q;
  out_item_t              out_item_q;

  logic                   accept;
  logic [2:0]             stype;
  logic                   full, empty, found;
  logic [NUMBER_BITS+15:0] num_in_ext;
  logic [NUMBER_BITS-1:0] next_ticket;
  cell_cmd_t              cmd;
  logic [NUMBER_BITS-1:0] key_num;
  logic [CountW-1:0]      pos;

  logic [NUMBER_BITS-1:0] cell_num  [QUEUE_DEPTH];
  logic [2:0]             cell_type [QUEUE_DEPTH];
  logic                   cell_prio [QUEUE_DEPTH];
  logic                   cell_hit  [QUEUE_DEPTH];
  logic                   cell_first[QUEUE_DEPTH];

  logic [NUMBER_BITS-1:0] sel_num;
  logic [2:0]             sel_type;
  logic                   sel_prio;

  status_e                res_status;
  logic [NUMBER_BITS-1:0] res_num;
  logic [2:0]             res_type;
  logic                   res_prio;
  logic [NUMBER_BITS+15:0] res_num_ext;
  logic [CountW+4:0]      occ_ext;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign stype       = norm_type(in_item_i.service_type);
  assign full        = (count_q == FullCount);
  assign empty       = (count_q == '0);
  assign num_in_ext  = {{NUMBER_BITS{1'b0}}, in_item_i.ticket_number};
  assign next_ticket = counter_q + NUMBER_BITS'(1);
  assign pos         = in_item_i.priority_req ? pcount_q : count_q;
  assign found       = cell_hit[QUEUE_DEPTH-1];

  always_comb begin
    cmd.stype = stype;
    cmd.prio  = in_item_i.priority_req;
    cmd.op    = CELL_HOLD;
    key_num   = num_in_ext[NUMBER_BITS-1:0];
    if (accept) begin
      unique case (in_item_i.opcode)
        OPC_ISSUE: begin
          key_num = next_ticket;
          if (!full) cmd.op = CELL_INSERT;
        end
        OPC_SERVE: begin
          if (!empty) cmd.op = CELL_SERVE;
        end
        OPC_CANCEL: cmd.op = CELL_CANCEL;
        OPC_NOP: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [NUMBER_BITS-1:0] left_num, right_num;
    logic [2:0]             left_type, right_type;
    logic                   left_prio, right_prio, hit_in;

    if (i == 0) begin : g_head
      assign left_num  = key_num;
      assign left_type = stype;
      assign left_prio = in_item_i.priority_req;
      assign hit_in    = (cmd.op == CELL_SERVE);
    end else begin : g_body
      assign left_num  = cell_num[i-1];
      assign left_type = cell_type[i-1];
      assign left_prio = cell_prio[i-1];
      assign hit_in    = cell_hit[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_num  = cell_num[i];
      assign right_type = cell_type[i];
      assign right_prio = cell_prio[i];
    end else begin : g_mid
      assign right_num  = cell_num[i+1];
      assign right_type = cell_type[i+1];
      assign right_prio = cell_prio[i+1];
    end

    tcpq_cell #(
      .INDEX      (i),
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .NUMBER_BITS(NUMBER_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .key_num_i   (key_num),
      .pos_i       (pos),
      .count_i     (count_q),
      .left_num_i  (left_num),
      .left_type_i (left_type),
      .left_prio_i (left_prio),
      .right_num_i (right_num),
      .right_type_i(right_type),
      .right_prio_i(right_prio),
      .hit_i       (hit_in),
      .hit_o       (cell_hit[i]),
      .first_o     (cell_first[i]),
      .num_o       (cell_num[i]),
      .type_o      (cell_type[i]),
      .prio_o      (cell_prio[i])
    );
  end

  always_comb begin
    sel_num  = '0;
    sel_type = '0;
    sel_prio = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cell_first[i]) begin
        sel_num  = sel_num | cell_num[i];
        sel_type = sel_type | cell_type[i];
        sel_prio = sel_prio | cell_prio[i];
      end
    end
  end

  always_comb begin
    count_d    = count_q;
    pcount_d   = pcount_q;
    counter_d  = counter_q;
    res_status = ST_OK;
    res_num    = '0;
    res_type   = '0;
    res_prio   = 1'b0;
    unique case (in_item_i.opcode)
      OPC_ISSUE: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          counter_d = next_ticket;
          count_d   = count_q + CountW'(1);
          if (in_item_i.priority_req) pcount_d = pcount_q + CountW'(1);
          res_num   = next_ticket;
          res_type  = stype;
          res_prio  = in_item_i.priority_req;
        end
      end
      OPC_SERVE: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          count_d  = count_q - CountW'(1);
          if (cell_prio[0]) pcount_d = pcount_q - CountW'(1);
          res_num  = cell_num[0];
          res_type = cell_type[0];
          res_prio = cell_prio[0];
        end
      end
      OPC_CANCEL: begin
        if (!found) begin
          res_status = ST_NOT_FOUND;
        end else begin
          count_d  = count_q - CountW'(1);
          if (sel_prio) pcount_d = pcount_q - CountW'(1);
          res_num  = sel_num;
          res_type = sel_type;
          res_prio = sel_prio;
        end
      end
      OPC_NOP: begin
      end
    endcase
  end

  assign res_num_ext = {16'b0, res_num};
  assign occ_ext     = {5'b0, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pcount_q    <= '0;
      counter_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q   <= count_d;
        pcount_q  <= pcount_d;
        counter_q <= counter_d;
      end
      out_valid_q <= accept | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q.status       <= res_status;
      out_item_q.out_number   <= res_num_ext[15:0];
      out_item_q.out_type     <= res_type;
      out_item_q.out_priority <= res_prio;
      out_item_q.occupancy    <= occ_ext[4:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

[hdl/tcpq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ticket queue cell
// One queue slot: holds a ticket, matches it against a cancel key and shifts
// toward either neighbor on insert or removal.
// ----------------------------------------------------------------------------
module tcpq_cell #(
  parameter int unsigned INDEX       = 0,
  parameter int unsigned QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned NUMBER_BITS = tcpq_pkg::NUMBER_BITS_DEF,
  localparam int unsigned CountW     = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                     clk_i,
  input  tcpq_pkg::cell_cmd_t     cmd_i,
  input  wire  [NUMBER_BITS-1:0]  key_num_i,
  input  wire  [CountW-1:0]       pos_i,
  input  wire  [CountW-1:0]       count_i,
  input  wire  [NUMBER_BITS-1:0]  left_num_i,
  input  wire  [2:0]              left_type_i,
  input  wire                     left_prio_i,
  input  wire  [NUMBER_BITS-1:0]  right_num_i,
  input  wire  [2:0]              right_type_i,
  input  wire                     right_prio_i,
  input  wire                     hit_i,
  output logic                    hit_o,
  output logic                    first_o,
  output logic [NUMBER_BITS-1:0]  num_o,
  output logic [2:0]              type_o,
  output logic                    prio_o
);
  import tcpq_pkg::*;

  localparam logic [CountW-1:0] Idx = CountW'(INDEX);

  logic [NUMBER_BITS-1:0] num_q, num_d;
  logic [2:0]             type_q, type_d;
  logic                   prio_q, prio_d;
  logic                   match;

  assign match = (cmd_i.op == CELL_CANCEL) && (Idx < count_i) &&
                 (num_q == key_num_i) && (type_q == cmd_i.stype) &&
                 (prio_q == cmd_i.prio);

  assign hit_o   = hit_i | match;
  assign first_o = match & ~hit_i;

  always_comb begin
    num_d  = num_q;
    type_d = type_q;
    prio_d = prio_q;
    unique case (cmd_i.op)
      CELL_INSERT: begin
        if (Idx > pos_i) begin
          num_d  = left_num_i;
          type_d = left_type_i;
          prio_d = left_prio_i;
        end else if (Idx == pos_i) begin
          num_d  = key_num_i;
          type_d = cmd_i.stype;
          prio_d = cmd_i.prio;
        end
      end
      CELL_SERVE, CELL_CANCEL: begin
        if (hit_o) begin
          num_d  = right_num_i;
          type_d = right_type_i;
          prio_d = right_prio_i;
        end
      end
      CELL_HOLD: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    type_q <= type_d;
    prio_q <= prio_d;
  end

  assign num_o  = num_q;
  assign type_o = type_q;
  assign prio_o = prio_q;

endmodule
`default_nettype wire

[hdl/tcpq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ticket queue checker
// Port-level checks on the result channel of the ticket queue.
// ----------------------------------------------------------------------------
`include "two_class_priority_ticket_queue_defines.svh"

module tcpq_checker #(
  parameter int unsigned QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF
) (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input tcpq_pkg::out_item_t out_item_o
);
  import tcpq_pkg::*;

  localparam logic [4:0] FullOcc = 5'(QUEUE_DEPTH);

  `TCPQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "stalled result changed")

  `TCPQ_ASSERT_IMPLY(a_full_occ, clk_i, rst_ni, out_valid_o && out_item_o.status == ST_FULL, out_item_o.occupancy == FullOcc, "full status with wrong occupancy")

  `TCPQ_ASSERT_IMPLY(a_empty_occ, clk_i, rst_ni, out_valid_o && out_item_o.status == ST_EMPTY, out_item_o.occupancy == 5'd0, "empty status with entries left")

  `TCPQ_ASSERT_IMPLY(a_fail_zero, clk_i, rst_ni, out_valid_o && (out_item_o.status == ST_EMPTY || out_item_o.status == ST_FULL || out_item_o.status == ST_NOT_FOUND), out_item_o.out_number == 16'd0 && out_item_o.out_type == 3'd0 && !out_item_o.out_priority, "failed transfer carries ticket data")

endmodule

bind two_class_priority_ticket_queue tcpq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_tcpq_checker (.*);
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ticket queue regression bench
// Drives issue, serve, cancel and idle operations into the two-class ticket
// queue through its valid/stall channels and predicts each result from an
// in-bench ordered ticket line. Covers the empty and full cases, class
// ordering, cancel hits and near misses, the folded service type and long
// random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
  import tcpq_pkg::*;

  localparam int unsigned LINE_DEPTH  = QUEUE_DEPTH_DEF;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          PHASE_ITEMS = 413;

  typedef struct packed {
    logic [15:0] number;
    logic [2:0]  stype;
    logic        prio;
  } ticket_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  ticket_t     ticket_line[$];
  int unsigned prio_in_line;
  logic [15:0] last_issued;
  out_item_t   pending_results[$];

  int send_idle_pct;
  int stall_pct;
  int errors;
  int cycle_count;
  int items_sent;
  int results_checked;
  int full_seen;
  int empty_seen;
  int miss_seen;
  int cancel_hits;

  two_class_priority_ticket_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("two_class_priority_ticket_queue regression: fail");
      $finish;
    end
  end

  function automatic in_item_t make_op(opcode_e op, logic [2:0] st, logic p,
                                       logic [15:0] n);
    in_item_t it;
    it.opcode        = op;
    it.service_type  = st;
    it.priority_req  = p;
    it.ticket_number = n;
    return it;
  endfunction

  function automatic out_item_t predict_ticket_op(in_item_t it);
    out_item_t   res;
    ticket_t     tk;
    logic [2:0]  st;
    int unsigned pos;
    bit          found;
    res   = '0;
    found = 1'b0;
    st    = (it.service_type > TYPE_UNKNOWN) ? TYPE_UNKNOWN : it.service_type;
    case (it.opcode)
      OPC_ISSUE: begin
        if (ticket_line.size() >= LINE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          last_issued = last_issued + 16'd1;
          tk.number = last_issued;
          tk.stype  = st;
          tk.prio   = it.priority_req;
          pos = tk.prio ? prio_in_line : ticket_line.size();
          ticket_line.insert(pos, tk);
          if (tk.prio) prio_in_line++;
          res.status       = ST_OK;
          res.out_number   = tk.number;
          res.out_type     = tk.stype;
          res.out_priority = tk.prio;
        end
      end
      OPC_SERVE: begin
        if (ticket_line.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          tk = ticket_line.pop_front();
          if (tk.prio) prio_in_line--;
          res.status       = ST_OK;
          res.out_number   = tk.number;
          res.out_type     = tk.stype;
          res.out_priority = tk.prio;
        end
      end
      OPC_CANCEL: begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < ticket_line.size() && !found; i++) begin
          if (ticket_line[i].prio == it.priority_req && ticket_line[i].stype == st &&
              ticket_line[i].number == it.ticket_number) begin
            tk = ticket_line[i];
            ticket_line.delete(i);
            if (tk.prio) prio_in_line--;
            found            = 1'b1;
            res.status       = ST_OK;
            res.out_number   = tk.number;
            res.out_type     = tk.stype;
            res.out_priority = tk.prio;
          end
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.occupancy = 5'(ticket_line.size());
    return res;
  endfunction

  task automatic send_op(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_ticket_op(it));
    items_sent++;
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: status %0d number %0d",
               out_item_o.status, out_item_o.out_number);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_item_o.status);
          errors++;
        end
        if (out_item_o.out_number !== want.out_number) begin
          $error("out_number: expected %0d, actual %0d", want.out_number,
                 out_item_o.out_number);
          errors++;
        end
        if (out_item_o.out_type !== want.out_type) begin
          $error("out_type: expected %0d, actual %0d", want.out_type, out_item_o.out_type);
          errors++;
        end
        if (out_item_o.out_priority !== want.out_priority) begin
          $error("out_priority: expected %0d, actual %0d", want.out_priority,
                 out_item_o.out_priority);
          errors++;
        end
        if (out_item_o.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", want.occupancy,
                 out_item_o.occupancy);
          errors++;
        end
        case (want.status)
          ST_FULL:      full_seen++;
          ST_EMPTY:     empty_seen++;
          ST_NOT_FOUND: miss_seen++;
          default:      ;
        endcase
        results_checked++;
      end
    end
  end

  task automatic test_empty_queue();
    send_op(make_op(OPC_SERVE, 3'd0, 1'b0, 16'h0000));
    send_op(make_op(OPC_CANCEL, 3'd7, 1'b1, 16'hFFFF));
    send_op(make_op(OPC_NOP, 3'd7, 1'b1, 16'hFFFF));
  endtask

  task automatic test_fill_and_cancel();
    ticket_t tk;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      send_op(make_op(OPC_ISSUE, 3'(i), logic'(i % 3 == 1), 16'(i * 4099)));
    end
    send_op(make_op(OPC_ISSUE, 3'd7, 1'b1, 16'hFFFF));
    tk = ticket_line[LINE_DEPTH - 2];
    send_op(make_op(OPC_CANCEL, (tk.stype == TYPE_UNKNOWN) ? 3'd7 : tk.stype, tk.prio,
                    tk.number));
    tk = ticket_line[0];
    send_op(make_op(OPC_CANCEL, tk.stype, ~tk.prio, tk.number));
    send_op(make_op(OPC_CANCEL, 3'd0, 1'b1, 16'hFFFF));
    send_op(make_op(OPC_SERVE, 3'd5, 1'b1, 16'h5555));
    send_op(make_op(OPC_SERVE, 3'd2, 1'b0, 16'hAAAA));
  endtask

  task automatic test_random_traffic(input int n_items);
    int      issue_weight;
    int      pick;
    ticket_t tk;
    logic [2:0] st;
    issue_weight = 40;
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 0) issue_weight = $urandom_range(15, 75);
      if ($urandom_range(99) < issue_weight) begin
        send_op(make_op(OPC_ISSUE, 3'($urandom_range(7)), 1'($urandom_range(1)),
                        16'($urandom)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          send_op(make_op(OPC_NOP, 3'($urandom_range(7)), 1'($urandom_range(1)),
                          16'($urandom)));
        end else if (pick < 45) begin
          send_op(make_op(OPC_SERVE, 3'($urandom_range(7)), 1'($urandom_range(1)),
                          16'($urandom)));
        end else if (ticket_line.size() != 0 && $urandom_range(9) < 7) begin
          tk = ticket_line[$urandom_range(ticket_line.size() - 1)];
          st = (tk.stype == TYPE_UNKNOWN && $urandom_range(1)) ? 3'd7 : tk.stype;
          case ($urandom_range(11))
            0:       tk.prio = ~tk.prio;
            1:       st = st ^ 3'd1;
            2:       tk.number = tk.number ^ (16'd1 << $urandom_range(15));
            default: cancel_hits++;
          endcase
          send_op(make_op(OPC_CANCEL, st, tk.prio, tk.number));
        end else begin
          send_op(make_op(OPC_CANCEL, 3'($urandom_range(7)), 1'($urandom_range(1)),
                          16'($urandom)));
        end
      end
    end
  endtask

  initial begin
    prio_in_line  = 0;
    last_issued   = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_fill_and_cancel();

    send_idle_pct = 0;  stall_pct = 0;
    test_random_traffic(PHASE_ITEMS);
    send_idle_pct = 48; stall_pct = 0;
    test_random_traffic(PHASE_ITEMS);
    send_idle_pct = 0;  stall_pct = 48;
    test_random_traffic(PHASE_ITEMS);
    send_idle_pct = 31; stall_pct = 31;
    test_random_traffic(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("ran %0d operations, checked %0d results in %0d cycles", items_sent,
             results_checked, cycle_count);
    $display("saw %0d full, %0d empty and %0d not-found replies; %0d aimed cancels",
             full_seen, empty_seen, miss_seen, cancel_hits);
    if (errors == 0) begin
      $display("two_class_priority_ticket_queue regression: pass");
    end else begin
      $display("two_class_priority_ticket_queue regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/tcpq_pkg.sv
hdl/tcpq_cell.sv
hdl/two_class_priority_ticket_queue.sv
hdl/tcpq_checker.sv
test/tb.sv
